FILE: rtl/utf8s_pkg.sv
// ----------------------------------------------------------------------------
// utf8s_pkg: shared types and constants of the UTF-8 stream sanitizer
// Lead byte decoding, code point limits and the width of sequence lengths.
// ----------------------------------------------------------------------------
`default_nettype none

package utf8s_pkg;

  // Sequence length, 0 for a byte that cannot start a sequence
  typedef logic [2:0] seq_len_t;

  // Code point as assembled from up to four bytes
  typedef logic [20:0] code_point_t;

  localparam seq_len_t LEN_NONE = 3'd0;
  localparam seq_len_t LEN_1    = 3'd1;
  localparam seq_len_t LEN_2    = 3'd2;
  localparam seq_len_t LEN_3    = 3'd3;
  localparam seq_len_t LEN_4    = 3'd4;

  // Lead prefixes of multi-byte sequences
  localparam logic [2:0] LEAD2_PREFIX = 3'b110;
  localparam logic [3:0] LEAD3_PREFIX = 4'hE;
  localparam logic [4:0] LEAD4_PREFIX = 5'h1E;
  localparam logic [1:0] CONT_PREFIX  = 2'b10;

  // Code point limits
  localparam code_point_t CP_MIN2     = 21'h00080;
  localparam code_point_t CP_MIN3     = 21'h00800;
  localparam code_point_t CP_MIN4     = 21'h10000;
  localparam code_point_t CP_MAX      = 21'h10FFFF;
  localparam code_point_t CP_SURR_LO  = 21'h0D800;
  localparam code_point_t CP_SURR_HI  = 21'h0DFFF;

  // Length announced by a lead byte
  function automatic seq_len_t lead_len(input logic [7:0] c);
    seq_len_t len;
    if (!c[7]) begin
      len = LEN_1;
    end else if (c[7:5] == LEAD2_PREFIX) begin
      len = LEN_2;
    end else if (c[7:4] == LEAD3_PREFIX) begin
      len = LEN_3;
    end else if (c[7:3] == LEAD4_PREFIX) begin
      len = LEN_4;
    end else begin
      len = LEN_NONE;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/utf8s_if.sv
// ----------------------------------------------------------------------------
// utf8s_in_if / utf8s_out_if: stream channels of the UTF-8 sanitizer
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------
`default_nettype none

interface utf8s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface utf8s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       string_done;

  modport source (output valid, output out_byte, output byte_valid, output string_done,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input string_done,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/utf8s_seq_check.sv
// ----------------------------------------------------------------------------
// utf8s_seq_check: well-formedness check of one held sequence
// Checks continuation bytes, overlong forms, surrogates and the upper limit.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8s_seq_check (
  input  wire logic [7:0]          byte0,
  input  wire logic [7:0]          byte1,
  input  wire logic [7:0]          byte2,
  input  wire logic [7:0]          byte3,
  input  wire utf8s_pkg::seq_len_t len,
  output logic                     ok
);

  utf8s_pkg::code_point_t cp;
  logic                   cont_ok;
  logic                   min_ok;

  // Assemble code point and check continuation markers
  always_comb begin
    cp      = '0;
    cont_ok = 1'b1;
    min_ok  = 1'b1;
    case (len)
      utf8s_pkg::LEN_1: begin
        cp = {14'd0, byte0[6:0]};
      end
      utf8s_pkg::LEN_2: begin
        cp      = {10'd0, byte0[4:0], byte1[5:0]};
        cont_ok = (byte1[7:6] == utf8s_pkg::CONT_PREFIX);
        min_ok  = (cp >= utf8s_pkg::CP_MIN2);
      end
      utf8s_pkg::LEN_3: begin
        cp      = {5'd0, byte0[3:0], byte1[5:0], byte2[5:0]};
        cont_ok = (byte1[7:6] == utf8s_pkg::CONT_PREFIX) &&
                  (byte2[7:6] == utf8s_pkg::CONT_PREFIX);
        min_ok  = (cp >= utf8s_pkg::CP_MIN3);
      end
      utf8s_pkg::LEN_4: begin
        cp      = {byte0[2:0], byte1[5:0], byte2[5:0], byte3[5:0]};
        cont_ok = (byte1[7:6] == utf8s_pkg::CONT_PREFIX) &&
                  (byte2[7:6] == utf8s_pkg::CONT_PREFIX) &&
                  (byte3[7:6] == utf8s_pkg::CONT_PREFIX);
        min_ok  = (cp >= utf8s_pkg::CP_MIN4);
      end
      default: begin
        cont_ok = 1'b0;
      end
    endcase
  end

  // Range checks on the assembled value
  assign ok = cont_ok && min_ok && (cp <= utf8s_pkg::CP_MAX) &&
              !((cp >= utf8s_pkg::CP_SURR_LO) && (cp <= utf8s_pkg::CP_SURR_HI));

endmodule

`default_nettype wire

FILE: rtl/utf8_stream_sanitizer_core.sv
// ----------------------------------------------------------------------------
// utf8_stream_sanitizer_core: passes only well-formed UTF-8 from a byte stream
// Holds up to four bytes, checks each complete sequence, drops bad lead bytes.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                | transfer
//  ---------+-----+----------------------------------------+------------------
//  in_ch    | in  | in_byte[7:0], end_of_string            | valid && ready
//  out_ch   | out | out_byte[7:0], byte_valid, string_done | valid && ready
//
//  Each byte is taken in S_IDLE. S_SCAN then examines lead bytes, dropping bad
//  ones and the lead of a rejected sequence, hands each good sequence to
//  S_EMIT, which passes its bytes on, and goes to S_FLUSH once the buffer is
//  empty or short. S_FLUSH closes the step and returns to S_IDLE; no new byte
//  is taken before that. The scan/emit sequencer sets this order.
//  Reset (synchronous, active low) empties the held bytes; no clearing pass.
//  A stall on out_ch holds the sequencer when a result cannot be placed.
// ----------------------------------------------------------------------------
`default_nettype none

module utf8_stream_sanitizer_core (
  input  wire logic clk,
  input  wire logic rst_n,
  utf8s_in_if.sink    in_ch,
  utf8s_out_if.source out_ch
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_EMIT, S_FLUSH} state_t;

  state_t              state_r, state_nxt;
  logic [7:0]          buf_r [4];
  logic [7:0]          buf_nxt [4];
  logic [2:0]          cnt_r, cnt_nxt;
  logic                eos_r, eos_nxt;
  logic [2:0]          left_r, left_nxt;
  logic                hold_vld_r, hold_vld_nxt;
  logic [7:0]          hold_byte_r, hold_byte_nxt;
  logic                out_vld_r, out_vld_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                out_bv_r, out_bv_nxt;
  logic                out_done_r, out_done_nxt;

  utf8s_pkg::seq_len_t front_len;
  logic                seq_ok;
  logic                out_free;
  logic                in_xfer;

  // Shared sequence checker on the front of the buffer
  utf8s_seq_check u_check (
    .byte0 (buf_r[0]),
    .byte1 (buf_r[1]),
    .byte2 (buf_r[2]),
    .byte3 (buf_r[3]),
    .len   (front_len),
    .ok    (seq_ok)
  );

  assign front_len = utf8s_pkg::lead_len(buf_r[0]);
  assign out_free  = !out_vld_r || out_ch.ready;
  assign in_xfer   = in_ch.valid && in_ch.ready;

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_vld_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.byte_valid  = out_bv_r;
  assign out_ch.string_done = out_done_r;

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    eos_nxt       = eos_r;
    left_nxt      = left_r;
    hold_vld_nxt  = hold_vld_r;
    hold_byte_nxt = hold_byte_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    out_byte_nxt  = out_byte_r;
    out_bv_nxt    = out_bv_r;
    out_done_nxt  = out_done_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          buf_nxt[cnt_r[1:0]] = in_ch.in_byte;
          cnt_nxt             = cnt_r + 3'd1;
          eos_nxt             = in_ch.end_of_string;
          state_nxt           = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_r == 3'd0) begin
          state_nxt = S_FLUSH;
        end else if (front_len == utf8s_pkg::LEN_NONE) begin
          buf_nxt = '{buf_r[1], buf_r[2], buf_r[3], buf_r[3]};
          cnt_nxt = cnt_r - 3'd1;
        end else if (cnt_r < front_len) begin
          state_nxt = S_FLUSH;
        end else if (seq_ok) begin
          left_nxt  = front_len;
          state_nxt = S_EMIT;
        end else begin
          buf_nxt = '{buf_r[1], buf_r[2], buf_r[3], buf_r[3]};
          cnt_nxt = cnt_r - 3'd1;
        end
      end
      S_EMIT: begin
        // one byte a cycle goes into the hold stage unless the older one cannot move out; the older one moves out
        if (!hold_vld_r || out_free) begin
          if (hold_vld_r) begin
            out_vld_nxt  = 1'b1;
            out_byte_nxt = hold_byte_r;
            out_bv_nxt   = 1'b1;
            out_done_nxt = 1'b0;
          end
          hold_vld_nxt  = 1'b1;
          hold_byte_nxt = buf_r[0];
          buf_nxt       = '{buf_r[1], buf_r[2], buf_r[3], buf_r[3]};
          cnt_nxt       = cnt_r - 3'd1;
          left_nxt      = left_r - 3'd1;
          if (left_r == 3'd1) begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_FLUSH: begin
        if (hold_vld_r || eos_r) begin
          if (out_free) begin
            out_vld_nxt  = 1'b1;
            out_byte_nxt = hold_vld_r ? hold_byte_r : 8'd0;
            out_bv_nxt   = hold_vld_r;
            out_done_nxt = eos_r;
            hold_vld_nxt = 1'b0;
            if (eos_r) begin
              cnt_nxt = 3'd0;
            end
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= 3'd0;
      hold_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      hold_vld_r <= hold_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
    buf_r       <= buf_nxt;
    eos_r       <= eos_nxt;
    left_r      <= left_nxt;
    hold_byte_r <= hold_byte_nxt;
    out_byte_r  <= out_byte_nxt;
    out_bv_r    <= out_bv_nxt;
    out_done_r  <= out_done_nxt;
  end

`ifndef SYNTHESIS
  // Held byte count never exceeds the buffer
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'd4) else $error("held byte count out of range");

  // Room for the next byte whenever a transfer can be taken
  a_idle_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (cnt_r <= 3'd3)) else $error("no room in idle");

  // Hold stage is always flushed before the next byte
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !hold_vld_r) else $error("hold left over in idle");

  // One byte at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready) else $error("ready after transfer");

  // A bare marker only ever closes a string
  a_bare_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_bv_r) |-> out_done_r) else $error("bare marker without done");
`endif

endmodule

`default_nettype wire

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for utf8_stream_sanitizer_core
// Drives byte strings over the input channel and checks every result against
// a UTF-8 sanitizing predictor. The run covers directed corner strings, then
// random strings, which are mostly well-formed text with some broken or
// illegal sequences mixed in. Random idling and stalling happen on both
// channels.
// ----------------------------------------------------------------------------

module tb;

  // Cycles without any transfer before the run is declared hung
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  // Receiver hold-off used to back the block up into its input
  localparam int unsigned LONG_HOLD = 400;
  // Settling time once nothing more is expected
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam int unsigned END_CYCLES = 50;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       done;
  } clean_item_t;

  // Predicts the sanitized stream and checks results in order
  class sanitizer_scoreboard;
    clean_item_t clean_out[$];
    logic [7:0]  held[4];
    int unsigned held_n;
    int unsigned fails;

    function new();
      held_n = 0;
      fails = 0;
    endfunction

    // Append one expected result at the tail
    function void add_result(clean_item_t item);
      clean_out = {clean_out, item};
    endfunction

    // Sequence length announced by a lead byte, 0 if it cannot lead
    function int lead_bytes(logic [7:0] c);
      int n;
      casez (c)
        8'b0???????: n = 1;
        8'b110?????: n = 2;
        8'b1110????: n = 3;
        8'b11110???: n = 4;
        default:     n = 0;
      endcase
      return n;
    endfunction

    // Continuation bytes, overlong forms, surrogates and the upper limit
    function bit well_formed(int len);
      utf8s_pkg::code_point_t cp;
      case (len)
        1:       cp = {14'd0, held[0][6:0]};
        2:       cp = {16'd0, held[0][4:0]};
        3:       cp = {17'd0, held[0][3:0]};
        default: cp = {18'd0, held[0][2:0]};
      endcase
      for (int j = 1; j < len; j++) begin
        if (held[j][7:6] != utf8s_pkg::CONT_PREFIX) return 1'b0;
        cp = {cp[14:0], held[j][5:0]};
      end
      if (len == 2 && cp < utf8s_pkg::CP_MIN2) return 1'b0;
      if (len == 3 && cp < utf8s_pkg::CP_MIN3) return 1'b0;
      if (len == 4 && cp < utf8s_pkg::CP_MIN4) return 1'b0;
      if (cp > utf8s_pkg::CP_MAX) return 1'b0;
      if (cp >= utf8s_pkg::CP_SURR_LO && cp <= utf8s_pkg::CP_SURR_HI) return 1'b0;
      return 1'b1;
    endfunction

    function void drop_front(int unsigned n);
      if (n >= held_n) begin
        held_n = 0;
      end else begin
        for (int unsigned i = 0; i < held_n - n; i++) held[i] = held[i + n];
        held_n = held_n - n;
      end
    endfunction

    // One accepted input byte: queue up the results it releases
    function void sanitize_byte(logic [7:0] b, logic eos);
      int unsigned len;
      int unsigned k;
      bit          scanning;
      clean_item_t tail;
      held[held_n] = b;
      held_n++;
      k = 0;
      scanning = 1'b1;
      while (scanning && held_n > 0) begin
        len = lead_bytes(held[0]);
        if (len == 0) begin
          drop_front(1);
        end else if (held_n < len) begin
          scanning = 1'b0;
        end else if (well_formed(len)) begin
          for (int unsigned j = 0; j < len; j++) begin
            add_result('{data: held[j], valid: 1'b1, done: 1'b0});
            k++;
          end
          drop_front(len);
        end else begin
          // rejected: only the lead goes, the rest is rescanned
          drop_front(1);
        end
      end
      // end of string: truncated tail is discarded, last result is marked
      if (eos) begin
        held_n = 0;
        if (k == 0) add_result('{data: 8'h00, valid: 1'b0, done: 1'b0});
        tail = clean_out.pop_back();
        tail.done = 1'b1;
        add_result(tail);
      end
    endfunction

    function void compare_result(logic [7:0] data, logic valid, logic done);
      clean_item_t want;
      if (clean_out.size() == 0) begin
        fails++;
        $display("%0t: unexpected result: out_byte %h byte_valid %b string_done %b",
                 $time, data, valid, done);
        return;
      end
      want = clean_out.pop_front();
      if (want.data !== data) begin
        fails++;
        $display("%0t: out_byte expected %h actual %h", $time, want.data, data);
      end
      if (want.valid !== valid) begin
        fails++;
        $display("%0t: byte_valid expected %b actual %b", $time, want.valid, valid);
      end
      if (want.done !== done) begin
        fails++;
        $display("%0t: string_done expected %b actual %b", $time, want.done, done);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  utf8s_in_if  in_ch ();
  utf8s_out_if out_ch ();

  utf8_stream_sanitizer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sanitizer_scoreboard sb;

  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned sent;
  int unsigned quiet;
  bit          hold_req;
  logic [7:0]  text[$];
  logic [7:0]  piece[$];

  // Clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Transfer monitor and watchdog
  initial quiet = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.sanitize_byte(in_ch.in_byte, in_ch.end_of_string);
      if (out_ch.valid && out_ch.ready) begin
        sb.compare_result(out_ch.out_byte, out_ch.byte_valid, out_ch.string_done);
      end
    end
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("utf8_stream_sanitizer_core: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // One byte over the input channel, with random gaps ahead of it
  task automatic send_byte(input logic [7:0] b, input logic eos);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.in_byte       <= b;
    in_ch.end_of_string <= eos;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic send_text();
    foreach (text[i]) send_byte(text[i], i == text.size() - 1);
  endtask

  // Sender goes quiet until every expected result is out
  task automatic drain_clean_out();
    in_ch.valid <= 1'b0;
    while (sb.clean_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Append one byte to the unit being built
  function automatic void add_piece_byte(logic [7:0] b);
    piece = {piece, b};
  endfunction

  // Encode a code point with a forced length (overlong forms allowed)
  function automatic void put_cp(utf8s_pkg::code_point_t cp, int len);
    case (len)
      1: add_piece_byte({1'b0, cp[6:0]});
      2: begin
        add_piece_byte({utf8s_pkg::LEAD2_PREFIX, cp[10:6]});
        add_piece_byte({utf8s_pkg::CONT_PREFIX, cp[5:0]});
      end
      3: begin
        add_piece_byte({utf8s_pkg::LEAD3_PREFIX, cp[15:12]});
        add_piece_byte({utf8s_pkg::CONT_PREFIX, cp[11:6]});
        add_piece_byte({utf8s_pkg::CONT_PREFIX, cp[5:0]});
      end
      default: begin
        add_piece_byte({utf8s_pkg::LEAD4_PREFIX, cp[20:18]});
        add_piece_byte({utf8s_pkg::CONT_PREFIX, cp[17:12]});
        add_piece_byte({utf8s_pkg::CONT_PREFIX, cp[11:6]});
        add_piece_byte({utf8s_pkg::CONT_PREFIX, cp[5:0]});
      end
    endcase
  endfunction

  // Random code point that is legal in its shortest form of this length
  function automatic utf8s_pkg::code_point_t legal_cp(int len);
    utf8s_pkg::code_point_t cp;
    case (len)
      1: cp = 21'($urandom_range(0, 8'h7F));
      2: cp = 21'($urandom_range(utf8s_pkg::CP_MIN2, utf8s_pkg::CP_MIN3 - 1));
      3: begin
        cp = 21'($urandom_range(utf8s_pkg::CP_MIN3, utf8s_pkg::CP_MIN4 - 1));
        if (cp >= utf8s_pkg::CP_SURR_LO && cp <= utf8s_pkg::CP_SURR_HI) begin
          cp = cp - 21'h800;
        end
      end
      default: cp = 21'($urandom_range(utf8s_pkg::CP_MIN4, utf8s_pkg::CP_MAX));
    endcase
    return cp;
  endfunction

  // Append one random unit: mostly valid text, some noise and broken forms
  task automatic add_random_unit();
    int unsigned pick;
    int unsigned len;
    utf8s_pkg::code_point_t floor_cp;
    pick = $urandom_range(0, 99);
    piece.delete();
    if (pick < 30) begin
      put_cp(legal_cp(1), 1);
    end else if (pick < 72) begin
      len = (pick < 45) ? 2 : (pick < 60) ? 3 : 4;
      put_cp(legal_cp(len), len);
    end else if (pick < 80) begin
      add_piece_byte(8'($urandom_range(0, 255)));
    end else if (pick < 86) begin
      // sequence cut short
      len = $urandom_range(2, 4);
      put_cp(legal_cp(len), len);
      repeat ($urandom_range(1, len - 1)) void'(piece.pop_back());
    end else if (pick < 92) begin
      // one continuation byte replaced by noise
      len = $urandom_range(2, 4);
      put_cp(legal_cp(len), len);
      piece[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
    end else if (pick < 96) begin
      // overlong form
      len = $urandom_range(2, 4);
      floor_cp = (len == 2) ? utf8s_pkg::CP_MIN2 :
                 (len == 3) ? utf8s_pkg::CP_MIN3 : utf8s_pkg::CP_MIN4;
      put_cp(21'($urandom_range(0, floor_cp - 1)), len);
    end else if ($urandom_range(0, 1)) begin
      put_cp(21'($urandom_range(utf8s_pkg::CP_SURR_LO, utf8s_pkg::CP_SURR_HI)), 3);
    end else begin
      // above U+10FFFF, lead bytes F4 through F7
      put_cp(21'($urandom_range(utf8s_pkg::CP_MAX + 1, 21'h1FFFFF)), 4);
    end
    foreach (piece[i]) text = {text, piece[i]};
  endtask

  task automatic send_random_strings(input int unsigned upto);
    while (sent < upto) begin
      text.delete();
      repeat ($urandom_range(1, 8)) add_random_unit();
      send_text();
    end
  endtask

  // Main sequence
  initial begin
    sb = new();
    sent = 0;
    hold_req = 1'b0;
    send_idle = 25;
    recv_idle = 76;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.end_of_string = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes, bad lead, overlong, minimum forms,
    // surrogate, above range, maximum, bad continuation, truncation
    text = '{8'h00, 8'h7F, 8'hFF};
    send_text();
    text = '{8'hC0, 8'h80};
    send_text();
    text = '{8'hE0, 8'hA0, 8'h80, 8'hED, 8'hA0, 8'h80,
             8'hF4, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text();
    text = '{8'hC2, 8'h41};
    send_text();
    text = '{8'hE2, 8'h82};
    send_text();

    // Sender idles lightly, receiver heavily
    send_random_strings(170);
    drain_clean_out();

    // Roles swapped
    send_idle = 76;
    recv_idle = 25;
    send_random_strings(320);
    drain_clean_out();

    // Full rate, with a long receiver hold-off at the start
    send_idle = 0;
    recv_idle = 0;
    hold_req = 1'b1;
    send_random_strings(460);
    drain_clean_out();

    repeat (END_CYCLES) @(posedge clk);
    if (sb.fails == 0 && sb.clean_out.size() == 0) begin
      $display("utf8_stream_sanitizer_core: match");
    end else begin
      $display("utf8_stream_sanitizer_core: mismatch");
    end
    $finish;
  end

endmodule
